@@ hdl/sse_pkg.sv @@
`timescale 1ns / 1ps

package sse_pkg;

    localparam int DATA_W  = 32;
    localparam int SPAN_W  = 33;
    localparam int COUNT_W = 5;
    localparam int FUNC_W  = 2;

    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd2;

    typedef struct packed {
        logic                     do_ins;
        logic                     do_rem;
        logic signed [DATA_W-1:0] key;
    } t_cell_ctrl;

endpackage

@@ hdl/sorted_set_engine.sv @@
`timescale 1ns / 1ps

// Sorted set of distinct signed 32-bit values, up to CAPACITY elements, held
// in a row of compare-and-shift cells. A request (insert, remove, lookup) is
// taken when start is high and busy is low; its result appears on the o_
// ports for one cycle with o_valid, after states EXEC and SPAN and the result
// register, and cannot be stalled. busy drops in that same result cycle, so
// a new request is taken no earlier than the prior result beat. EXEC
// compares all cells and shifts the row; SPAN picks the largest element and
// forms the span. An unused func code changes nothing and reports ok low.
module sorted_set_engine #(
    parameter int CAPACITY = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    input  logic [sse_pkg::FUNC_W-1:0]         i_func,
    input  logic signed [sse_pkg::DATA_W-1:0]  i_value,
    output logic                               busy,
    output logic                               o_valid,
    output logic                               o_ok,
    output logic [sse_pkg::COUNT_W-1:0]        o_count,
    output logic                               o_is_empty,
    output logic signed [sse_pkg::SPAN_W-1:0]  o_max_minus_min
);
    import sse_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_SPAN = 3'b100
    } t_state;

    t_state                   r_state, n_state;
    logic [FUNC_W-1:0]        r_func;
    logic signed [DATA_W-1:0] r_key;
    logic [CNT_W-1:0]         r_count, n_count;
    logic                     r_ok, n_ok;
    logic                     r_valid;
    logic                     r_res_ok;
    logic [COUNT_W-1:0]       r_res_count;
    logic                     r_res_empty;
    logic signed [SPAN_W-1:0] r_res_span;

    t_cell_ctrl               cell_ctrl;
    logic [CAPACITY:0]        occ;
    logic [CAPACITY-1:0]      lt_vec, eq_vec, last_vec;
    logic signed [DATA_W-1:0] cell_val [CAPACITY];
    logic signed [DATA_W-1:0] max_val;
    logic signed [SPAN_W-1:0] span;
    logic                     found;
    logic                     accept;

    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);

    assign occ[CAPACITY] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            assign occ[gi] = (r_count > CNT_W'(gi));
            assign last_vec[gi] = occ[gi] && !occ[gi+1];
            sse_cell u_cell (
                .i_clk     (i_clk),
                .i_ctrl    (cell_ctrl),
                .i_occ     (occ[gi]),
                .i_prev_lt ((gi == 0) ? 1'b1 : lt_vec[(gi == 0) ? 0 : gi-1]),
                .i_prev_val(cell_val[(gi == 0) ? 0 : gi-1]),
                .i_next_val(cell_val[(gi == CAPACITY-1) ? gi : gi+1]),
                .o_val     (cell_val[gi]),
                .o_lt      (lt_vec[gi]),
                .o_eq      (eq_vec[gi])
            );
        end
    endgenerate

    assign found = |eq_vec;

    always_comb begin
        cell_ctrl.key    = r_key;
        cell_ctrl.do_ins = (r_state == ST_EXEC) && (r_func == FN_INSERT) && !found
                           && (r_count < CNT_W'(CAPACITY));
        cell_ctrl.do_rem = (r_state == ST_EXEC) && (r_func == FN_REMOVE) && found;
    end

    always_comb begin
        max_val = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            max_val = max_val | (cell_val[i] & {DATA_W{last_vec[i]}});
        end
    end

    always_comb begin
        if (r_count == '0) begin
            span = '1;
        end else begin
            span = {max_val[DATA_W-1], max_val} - {cell_val[0][DATA_W-1], cell_val[0]};
        end
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ok    = r_ok;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_SPAN;
                n_ok    = cell_ctrl.do_ins || cell_ctrl.do_rem
                          || ((r_func == FN_LOOKUP) && found);
                if (cell_ctrl.do_ins) begin
                    n_count = r_count + CNT_W'(1);
                end else if (cell_ctrl.do_rem) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            ST_SPAN: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= (r_state == ST_SPAN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_func;
            r_key  <= i_value;
        end
        r_ok <= n_ok;
        if (r_state == ST_SPAN) begin
            r_res_ok    <= r_ok;
            r_res_count <= COUNT_W'(r_count);
            r_res_empty <= (r_count == '0);
            r_res_span  <= span;
        end
    end

    assign o_valid         = r_valid;
    assign o_ok            = r_res_ok;
    assign o_count         = r_res_count;
    assign o_is_empty      = r_res_empty;
    assign o_max_minus_min = r_res_span;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_count_moves_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_EXEC) |=> $stable(r_count))
        else $error("element count changed outside execute");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("request accepted without going busy");

    a_beat_three: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##2 (o_valid && !busy))
        else $error("result beat not three cycles after accept");

    a_empty_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_empty) |-> (o_max_minus_min == '1 && !(o_ok && r_func == FN_LOOKUP)))
        else $error("empty set reported with span or lookup hit");

endmodule

@@ hdl/sse_cell.sv @@
`timescale 1ns / 1ps

module sse_cell (
    input  logic                              i_clk,
    input  sse_pkg::t_cell_ctrl               i_ctrl,
    input  logic                              i_occ,
    input  logic                              i_prev_lt,
    input  logic signed [sse_pkg::DATA_W-1:0] i_prev_val,
    input  logic signed [sse_pkg::DATA_W-1:0] i_next_val,
    output logic signed [sse_pkg::DATA_W-1:0] o_val,
    output logic                              o_lt,
    output logic                              o_eq
);
    import sse_pkg::*;

    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] n_val;

    assign o_lt  = i_occ && (r_val < i_ctrl.key);
    assign o_eq  = i_occ && (r_val == i_ctrl.key);
    assign o_val = r_val;

    // cells below the insertion or removal point hold; the rest shift by one
    always_comb begin
        n_val = r_val;
        if (i_ctrl.do_ins && !o_lt) begin
            n_val = i_prev_lt ? i_ctrl.key : i_prev_val;
        end else if (i_ctrl.do_rem && !o_lt) begin
            n_val = i_next_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

@@ tb/sv/tb_sorted_set_engine.sv @@
`timescale 1ns / 1ps

module tb_sorted_set_engine;

    import sse_pkg::*;

    localparam int CAPACITY      = 16;
    localparam int STALL_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 500;
    localparam int MAX_REPORTS   = 10;

    localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic                ok;
        logic [COUNT_W-1:0]  count;
        logic                is_empty;
        logic [SPAN_W-1:0]   span;
    } t_set_status;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic [FUNC_W-1:0]         i_func;
    logic signed [DATA_W-1:0]  i_value;
    logic                      busy;
    logic                      o_valid;
    logic                      o_ok;
    logic [COUNT_W-1:0]        o_count;
    logic                      o_is_empty;
    logic signed [SPAN_W-1:0]  o_max_minus_min;

    logic signed [DATA_W-1:0]  set_vals [CAPACITY];
    int                        set_count;
    t_set_status               exp_status_q [$];
    int                        sender_idle_pct;
    int                        mismatches;
    int                        stall_cycles;
    t_set_status               exp_st;
    t_set_status               got_st;

    sorted_set_engine #(
        .CAPACITY(CAPACITY)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .i_func          (i_func),
        .i_value         (i_value),
        .busy            (busy),
        .o_valid         (o_valid),
        .o_ok            (o_ok),
        .o_count         (o_count),
        .o_is_empty      (o_is_empty),
        .o_max_minus_min (o_max_minus_min)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_set_status apply_set_op(input logic [FUNC_W-1:0] fn,
                                                 input logic signed [DATA_W-1:0] v);
        int                        pos;
        int                        i;
        logic                      hit;
        logic signed [SPAN_W-1:0]  hi;
        logic signed [SPAN_W-1:0]  lo;
        t_set_status               st;
        pos = 0;
        while (pos < set_count && set_vals[pos] < v)
            pos++;
        hit = (pos < set_count) && (set_vals[pos] == v);
        st.ok = 1'b0;
        case (fn)
            FN_INSERT: begin
                if (!hit && set_count < CAPACITY) begin
                    for (i = set_count; i > pos; i--)
                        set_vals[i] = set_vals[i-1];
                    set_vals[pos] = v;
                    set_count++;
                    st.ok = 1'b1;
                end
            end
            FN_REMOVE: begin
                if (hit) begin
                    for (i = pos; i + 1 < set_count; i++)
                        set_vals[i] = set_vals[i+1];
                    set_count--;
                    st.ok = 1'b1;
                end
            end
            FN_LOOKUP: begin
                st.ok = hit;
            end
            default: begin
            end
        endcase
        st.count    = set_count[COUNT_W-1:0];
        st.is_empty = (set_count == 0);
        if (set_count == 0) begin
            st.span = '1;
        end else begin
            hi      = set_vals[set_count-1];
            lo      = set_vals[0];
            st.span = hi - lo;
        end
        return st;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40 && set_count > 0)
            return set_vals[$urandom_range(0, set_count - 1)];
        if (sel < 70)
            return int'($urandom_range(0, 15)) - 8;
        if (sel < 90)
            return $urandom;
        case ($urandom_range(0, 3))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return 0;
            default: return -1;
        endcase
    endfunction

    function automatic logic [FUNC_W-1:0] pick_func(input logic filling);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 3)
            return FN_SPARE;
        if (sel < 25)
            return FN_LOOKUP;
        if (filling)
            return (sel < 75) ? FN_INSERT : FN_REMOVE;
        return (sel < 45) ? FN_INSERT : FN_REMOVE;
    endfunction

    // one request beat; start stays high when the next beat follows at once
    task automatic send_beat(input logic [FUNC_W-1:0] fn,
                             input logic signed [DATA_W-1:0] v);
        int gap;
        start   <= 1'b1;
        i_func  <= fn;
        i_value <= v;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        exp_status_q.push_back(apply_set_op(fn, v));
        gap = 0;
        while ($urandom_range(0, 99) < sender_idle_pct)
            gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (exp_status_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_random_ops(input int n);
        int   k;
        logic filling;
        filling = 1'b1;
        for (k = 0; k < n; k++) begin
            if (k % 40 == 39)
                filling = $urandom_range(0, 1);
            send_beat(pick_func(filling), pick_value());
        end
        wait_drained();
    endtask

    task automatic test_directed();
        int k;
        sender_idle_pct = 0;
        send_beat(FN_LOOKUP, 0);
        send_beat(FN_REMOVE, 5);
        send_beat(FN_SPARE, 0);
        send_beat(FN_INSERT, 0);
        send_beat(FN_REMOVE, 0);
        send_beat(FN_INSERT, VAL_MIN);
        send_beat(FN_INSERT, VAL_MAX);
        send_beat(FN_INSERT, VAL_MAX);
        send_beat(FN_LOOKUP, VAL_MIN);
        send_beat(FN_LOOKUP, -1);
        send_beat(FN_REMOVE, 3);
        for (k = 1; k <= CAPACITY - 2; k++)
            send_beat(FN_INSERT, k * 1000 - 7000);
        send_beat(FN_INSERT, 42);
        send_beat(FN_SPARE, 9);
        wait_drained();
    endtask

    task automatic test_random_light_gaps();
        sender_idle_pct = 14;
        run_random_ops(RANDOM_ITEMS);
    endtask

    task automatic test_random_heavy_gaps();
        sender_idle_pct = 58;
        run_random_ops(RANDOM_ITEMS);
    endtask

    task automatic test_random_back_to_back();
        sender_idle_pct = 0;
        run_random_ops(RANDOM_ITEMS);
    endtask

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else if (i_rst_n && o_valid) begin
            got_st = {o_ok, o_count, o_is_empty, o_max_minus_min};
            if (exp_status_q.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result beat: ok=%0b count=%0d empty=%0b span=%h",
                             got_st.ok, got_st.count, got_st.is_empty, got_st.span);
                mismatches++;
            end else begin
                exp_st = exp_status_q.pop_front();
                if (got_st !== exp_st) begin
                    if (mismatches < MAX_REPORTS)
                        $display("mismatch: exp ok=%0b count=%0d empty=%0b span=%h | %s%0b %0d %0b %h",
                                 exp_st.ok, exp_st.count, exp_st.is_empty, exp_st.span,
                                 "got ", got_st.ok, got_st.count, got_st.is_empty,
                                 got_st.span);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_func          <= FN_INSERT;
        i_value         <= '0;
        sender_idle_pct = 0;
        set_count       = 0;
        mismatches      = 0;
        stall_cycles    = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_light_gaps();
        test_random_heavy_gaps();
        test_random_back_to_back();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && exp_status_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
